FILE: rtl/drbc_pkg.sv
// ----------------------------------------------------------------------------
// drbc_pkg
// shared types and constants for the relaxed body canonicaliser
// ----------------------------------------------------------------------------
package drbc_pkg;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam int CNT_W = 32;

  localparam logic [0:0] REQ_BYTE = 1'b0;
  localparam logic [0:0] REQ_EOB  = 1'b1;

  localparam logic [0:0] KIND_BYTE = 1'b0;
  localparam logic [0:0] KIND_RUN  = 1'b1;

  // result steps of one command, lowest bit goes first
  localparam int STEP_N = 5;
  localparam logic [STEP_N-1:0] STEP_RUN  = 5'b00001;
  localparam logic [STEP_N-1:0] STEP_SP   = 5'b00010;
  localparam logic [STEP_N-1:0] STEP_CR   = 5'b00100;
  localparam logic [STEP_N-1:0] STEP_BYTE = 5'b01000;
  localparam logic [STEP_N-1:0] STEP_FIN  = 5'b10000;

  // queue geometry
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [STEP_N-1:0] steps;
    logic [CNT_W-1:0]  run_cnt;
    logic [7:0]        data;
  } drbc_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } drbc_qstat_t;

endpackage

FILE: rtl/drbc_in_if.sv
// ----------------------------------------------------------------------------
// drbc_in_if
// raw body word channel
// ----------------------------------------------------------------------------
interface drbc_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

FILE: rtl/drbc_out_if.sv
// ----------------------------------------------------------------------------
// drbc_out_if
// canonical body result channel
// ----------------------------------------------------------------------------
interface drbc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic [31:0] crlf_pairs;
  logic        last;

  modport source (output valid, output kind, output out_byte, output crlf_pairs,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input crlf_pairs,
                  input last, output ready);
endinterface

FILE: rtl/drbc_front.sv
// ----------------------------------------------------------------------------
// drbc_front
// classifies body words, tracks line state and issues result commands
// ----------------------------------------------------------------------------
module drbc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                req_type,
  input  logic [7:0]          in_byte,
  output logic                push,
  output drbc_pkg::drbc_cmd_t cmd
);
  import drbc_pkg::*;

  logic             pend_space_r, pend_space_nxt;
  logic             pend_cr_r, pend_cr_nxt;
  logic [CNT_W-1:0] defer_r, defer_nxt;

  logic is_eob, is_lf, is_cr, is_ws, byte_content, flush_cr, any_content;

  always_comb begin
    is_eob       = (req_type == REQ_EOB);
    is_lf        = !is_eob && (in_byte == CH_LF);
    is_cr        = !is_eob && (in_byte == CH_CR);
    is_ws        = !is_eob && ((in_byte == CH_SP) || (in_byte == CH_TAB));
    byte_content = !is_eob && !is_lf && !is_cr && !is_ws;
    flush_cr     = pend_cr_r && !is_lf;
    any_content  = flush_cr || byte_content;

    cmd.steps   = '0;
    cmd.run_cnt = defer_r;
    cmd.data    = in_byte;
    if (any_content && (defer_r != '0)) begin
      cmd.steps = cmd.steps | STEP_RUN;
    end
    if (any_content && pend_space_r) begin
      cmd.steps = cmd.steps | STEP_SP;
    end
    if (flush_cr) begin
      cmd.steps = cmd.steps | STEP_CR;
    end
    if (byte_content) begin
      cmd.steps = cmd.steps | STEP_BYTE;
    end
    if (is_eob) begin
      cmd.steps = cmd.steps | STEP_FIN;
    end
    push = fire && (cmd.steps != '0);

    if (is_eob) begin
      pend_space_nxt = 1'b0;
      pend_cr_nxt    = 1'b0;
      defer_nxt      = '0;
    end else begin
      pend_cr_nxt    = is_cr;
      pend_space_nxt = is_ws || (pend_space_r && !any_content && !is_lf);
      if (is_lf) begin
        defer_nxt = (defer_r == '1) ? defer_r : defer_r + CNT_W'(1);
      end else if (any_content) begin
        defer_nxt = '0;
      end else begin
        defer_nxt = defer_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_space_r <= 1'b0;
      pend_cr_r    <= 1'b0;
      defer_r      <= '0;
    end else if (fire) begin
      pend_space_r <= pend_space_nxt;
      pend_cr_r    <= pend_cr_nxt;
      defer_r      <= defer_nxt;
    end
  end
endmodule

FILE: rtl/drbc_queue.sv
// ----------------------------------------------------------------------------
// drbc_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module drbc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  drbc_pkg::drbc_cmd_t  push_cmd,
  input  logic                 pop,
  output drbc_pkg::drbc_cmd_t  head,
  output drbc_pkg::drbc_qstat_t stat
);
  import drbc_pkg::*;

  drbc_cmd_t          slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + Q_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - Q_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end
endmodule

FILE: rtl/drbc_back.sv
// ----------------------------------------------------------------------------
// drbc_back
// expands queued commands into result words through an output register
// ----------------------------------------------------------------------------
module drbc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  drbc_pkg::drbc_cmd_t   head,
  input  drbc_pkg::drbc_qstat_t stat,
  output logic                  pop,
  drbc_out_if.source            out_ch
);
  import drbc_pkg::*;

  logic [STEP_N-1:0] done_r, pend, sel;
  logic              out_valid_r;
  logic              kind_r, last_r;
  logic [7:0]        byte_r;
  logic [CNT_W-1:0]  pairs_r;
  logic              load;
  logic              kind_nxt, last_nxt;
  logic [7:0]        byte_nxt;
  logic [CNT_W-1:0]  pairs_nxt;

  always_comb begin
    load = !stat.empty && (!out_valid_r || out_ch.ready);
    pend = head.steps & ~done_r;
    sel  = pend & (~pend + STEP_N'(1));
    pop  = load && ((pend & ~sel) == '0);

    kind_nxt  = KIND_BYTE;
    last_nxt  = 1'b0;
    byte_nxt  = '0;
    pairs_nxt = '0;
    unique case (sel)
      STEP_RUN: begin
        kind_nxt  = KIND_RUN;
        pairs_nxt = head.run_cnt;
      end
      STEP_SP:   byte_nxt = CH_SP;
      STEP_CR:   byte_nxt = CH_CR;
      STEP_BYTE: byte_nxt = head.data;
      STEP_FIN: begin
        kind_nxt  = KIND_RUN;
        pairs_nxt = CNT_W'(1);
        last_nxt  = 1'b1;
      end
      default: begin
        kind_nxt = KIND_BYTE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        done_r      <= pop ? '0 : (done_r | sel);
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= kind_nxt;
      last_r  <= last_nxt;
      byte_r  <= byte_nxt;
      pairs_r <= pairs_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.last       = last_r;
  assign out_ch.out_byte   = byte_r;
  assign out_ch.crlf_pairs = pairs_r;
endmodule

FILE: rtl/dkim_relaxed_body_canon.sv
// ----------------------------------------------------------------------------
// dkim_relaxed_body_canon
// relaxed body canonicaliser: raw body words in, canonical body words out
// ----------------------------------------------------------------------------
//   channel  | dir | payload                            | handshake
//   in_ch    | in  | req_type, in_byte                  | valid / ready
//   out_ch   | out | kind, out_byte, crlf_pairs, last   | valid / ready
//
// one input word per cycle while in_ch.ready is high; each result word is
// held in the output register until taken, so a word giving k results holds
// the back end until all k are out; a two-entry command queue absorbs this,
// and in_ch.ready drops only while the queue is full
// words that give no result (line ends, whitespace, a held cr) skip the queue
// rst_n is synchronous and clears line state, queue and output register
// ----------------------------------------------------------------------------
module dkim_relaxed_body_canon (
  input  logic       clk,
  input  logic       rst_n,
  drbc_in_if.sink    in_ch,
  drbc_out_if.source out_ch
);
  import drbc_pkg::*;

  drbc_cmd_t   cmd, head;
  drbc_qstat_t stat;
  logic        fire, push, pop;

  assign in_ch.ready = !stat.full;
  assign fire        = in_ch.valid && in_ch.ready;

  drbc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .req_type (in_ch.req_type),
    .in_byte  (in_ch.in_byte),
    .push     (push),
    .cmd      (cmd)
  );

  drbc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  drbc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .stat   (stat),
    .pop    (pop),
    .out_ch (out_ch)
  );
endmodule
